>>> rtl/tmcw_pkg.sv
// Shared types and constants for the text-mode console writer.
// Holds opcodes, character codes, the command kind and the back-end status struct.
// No dependencies.
package tmcw_pkg;

  localparam logic [1:0] OP_EMIT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [7:0] RESET_ATTR = 8'h07;

  localparam int IDX_W   = 11;
  localparam int Q_DEPTH = 2;
  localparam int QAW     = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    K_PRINT,
    K_LF,
    K_CR,
    K_TAB,
    K_BS,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       ch;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

>>> rtl/tmcw_if.sv
// Channel interfaces of the text-mode console writer: input, result and configuration.
// Each carries valid, ready and its payload. Depends on tmcw_pkg.
interface tmcw_in_if import tmcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [7:0]       char_code;
  logic [IDX_W-1:0] cell_index;
  modport source (output valid, opcode, char_code, cell_index, input ready);
  modport sink (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tmcw_out_if ();
  logic        valid;
  logic        ready;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [15:0] cell_value;
  logic        scrolled;
  modport source (output valid, cursor_row, cursor_col, cell_value, scrolled, input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_value, scrolled, output ready);
endinterface

interface tmcw_cfg_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_attribute;
  modport source (output valid, text_attribute, input ready);
  modport sink (input valid, text_attribute, output ready);
endinterface

>>> rtl/tmcw_front.sv
// Front end: accept input transactions, classify them into commands and register them.
// Depends on tmcw_pkg and tmcw_if.
module tmcw_front import tmcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  tmcw_in_if.sink       in_ch,
  input  back_stat_t    stat,
  output logic          push_valid,
  input  logic          push_ready,
  output cmd_t          push_cmd
);

  localparam int CELLS = ROWS * COLUMNS;

  logic f_valid_r, f_valid_nxt;
  cmd_t f_cmd_r;
  cmd_t cls;
  logic accept;

  always_comb begin
    cls.ch   = in_ch.char_code;
    cls.idx  = in_ch.cell_index;
    cls.kind = K_NOP;
    unique case (in_ch.opcode)
      OP_EMIT: begin
        case (in_ch.char_code)
          CH_LF:   cls.kind = K_LF;
          CH_CR:   cls.kind = K_CR;
          CH_TAB:  cls.kind = K_TAB;
          CH_BS:   cls.kind = K_BS;
          default: cls.kind = K_PRINT;
        endcase
      end
      OP_CLEAR: cls.kind = K_CLEAR;
      OP_READ: begin
        // out-of-range reads report zero and touch nothing
        cls.kind = (32'(in_ch.cell_index) < 32'(CELLS)) ? K_READ : K_NOP;
      end
      default: cls.kind = K_NOP;
    endcase
  end

  assign in_ch.ready = !stat.init_busy && (!f_valid_r || push_ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = f_valid_r;
  assign push_cmd    = f_cmd_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push_ready) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd_r <= cls;
    end
  end

endmodule

>>> rtl/tmcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tmcw_pkg.
module tmcw_queue import tmcw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t           ent_r [Q_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != (QAW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/tmcw_back.sv
// Back end: cell store, cursor, attribute register, sequencer and result register.
// Depends on tmcw_pkg and tmcw_if.
module tmcw_back import tmcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  tmcw_out_if.source  out_ch,
  tmcw_cfg_if.sink    cfg_ch,
  output back_stat_t  stat
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RCW   = $clog2(ROWS);
  localparam int CCW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLUMNS + 8);
  localparam logic [AW-1:0] SCROLL_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_SPAN    = AW'(COLUMNS);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RDWAIT = 5'b00100,
    ST_COPY   = 5'b01000,
    ST_FILL   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [RCW-1:0]  row_r, row_nxt;
  logic [CCW-1:0]  col_r, col_nxt;
  logic [7:0]      attr_r;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            pend_r, pend_nxt;
  logic [15:0]     fill_val_r, fill_val_nxt;
  logic            scr_r, scr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [4:0]      o_row_r, o_row_nxt;
  logic [6:0]      o_col_r, o_col_nxt;
  logic [15:0]     o_val_r, o_val_nxt;
  logic            o_scr_r, o_scr_nxt;

  logic [15:0]     mem [CELLS];
  logic [15:0]     rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [15:0]     mem_wd;

  logic            pop;
  logic [RW-1:0]   row_n;
  logic [CW-1:0]   col_n;
  logic            wr_cell;
  logic [CCW-1:0]  wr_col;
  logic [7:0]      wr_char;
  logic            needs_scroll;
  logic [AW-1:0]   cur_addr;

  assign pop     = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_ch.ready);
  assign q_ready = pop;

  assign stat.init_busy = (state_r == ST_INIT);
  assign cfg_ch.ready   = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_row = o_row_r;
  assign out_ch.cursor_col = o_col_r;
  assign out_ch.cell_value = o_val_r;
  assign out_ch.scrolled   = o_scr_r;

  // cursor movement for emit commands
  always_comb begin
    row_n   = RW'(row_r);
    col_n   = CW'(col_r);
    wr_cell = 1'b0;
    wr_col  = col_r;
    wr_char = q_cmd.ch;
    case (q_cmd.kind)
      K_PRINT: begin
        wr_cell = 1'b1;
        col_n   = CW'(col_r) + CW'(1);
      end
      K_LF: begin
        col_n = '0;
        row_n = RW'(row_r) + RW'(1);
      end
      K_CR: col_n = '0;
      K_TAB: col_n = (CW'(col_r) + CW'(8)) & ~CW'(7);
      K_BS: begin
        if (col_r != '0) begin
          col_n   = CW'(col_r) - CW'(1);
          wr_cell = 1'b1;
          wr_col  = col_r - CCW'(1);
          wr_char = CH_BLANK;
        end
      end
      default: ;
    endcase
    if (col_n >= CW'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + RW'(1);
    end
  end

  assign needs_scroll = (row_n == RW'(ROWS));
  assign cur_addr     = AW'(AW'(row_r) * AW'(COLUMNS)) + AW'(wr_col);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    fill_val_nxt  = fill_val_r;
    scr_nxt       = scr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_row_nxt     = o_row_r;
    o_col_nxt     = o_col_r;
    o_val_nxt     = o_val_r;
    o_scr_nxt     = o_scr_r;
    mem_we        = 1'b0;
    mem_wa        = ptr_r;
    mem_wd        = fill_val_r;
    mem_ra        = AW'(q_cmd.idx);
    unique case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.kind)
            K_CLEAR: begin
              row_nxt      = '0;
              col_nxt      = '0;
              ptr_nxt      = '0;
              fill_val_nxt = {attr_r, CH_BLANK};
              scr_nxt      = 1'b0;
              state_nxt    = ST_FILL;
            end
            K_READ: state_nxt = ST_RDWAIT;
            K_NOP: begin
              out_valid_nxt = 1'b1;
              o_row_nxt     = 5'(row_r);
              o_col_nxt     = 7'(col_r);
              o_val_nxt     = '0;
              o_scr_nxt     = 1'b0;
            end
            default: begin
              mem_we = wr_cell;
              mem_wa = cur_addr;
              mem_wd = {attr_r, wr_char};
              col_nxt = CCW'(col_n);
              if (needs_scroll) begin
                row_nxt      = RCW'(ROWS - 1);
                ptr_nxt      = '0;
                fill_val_nxt = {attr_r, CH_BLANK};
                scr_nxt      = 1'b1;
                state_nxt    = ST_COPY;
              end else begin
                row_nxt       = RCW'(row_n);
                out_valid_nxt = 1'b1;
                o_row_nxt     = 5'(row_n);
                o_col_nxt     = 7'(col_n);
                o_val_nxt     = '0;
                o_scr_nxt     = 1'b0;
              end
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        o_row_nxt     = 5'(row_r);
        o_col_nxt     = 7'(col_r);
        o_val_nxt     = rd_data_r;
        o_scr_nxt     = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_COPY: begin
        // read one row below, write the previous read back one row up
        mem_we = pend_r;
        mem_wa = ptr_r - AW'(1);
        mem_wd = rd_data_r;
        mem_ra = ptr_r + ROW_SPAN;
        if (ptr_r == SCROLL_BASE) begin
          state_nxt = ST_FILL;
        end else begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + AW'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          o_row_nxt     = 5'(row_r);
          o_col_nxt     = 7'(col_r);
          o_val_nxt     = '0;
          o_scr_nxt     = scr_r;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= RESET_ATTR;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      fill_val_r  <= {RESET_ATTR, CH_BLANK};
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      fill_val_r  <= fill_val_nxt;
      scr_r       <= scr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        attr_r <= cfg_ch.text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    o_row_r <= o_row_nxt;
    o_col_r <= o_col_nxt;
    o_val_r <= o_val_nxt;
    o_scr_r <= o_scr_nxt;
  end

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (32'(col_r) < 32'(COLUMNS)))
    else $error("cursor outside the screen");

  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) && (ptr_r == LAST_CELL) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("fill pass ended without a result");

  a_read_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDWAIT) |-> ($past(state_r) == ST_IDLE))
    else $error("read wait not entered from idle");

  a_copy_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> (row_r == RCW'(ROWS - 1)) && scr_r)
    else $error("scroll copy without the cursor on the bottom row");

endmodule

>>> rtl/text_mode_console_writer_top.sv
// Top level of the text-mode console writer.
// Depends on tmcw_pkg, tmcw_if, tmcw_front, tmcw_queue and tmcw_back.

// Text-mode screen engine holding ROWS x COLUMNS cells (attribute byte over character
// byte) and a cursor. Each input transaction gives exactly one result transaction.
// Timing: a printable character, newline, carriage return, tab or backspace that does
// not scroll is handled in ST_IDLE alone, so such transactions stream at one per cycle
// while out_ch.ready is high, passing through the front register, the queue and the
// result register. A read passes through ST_RDWAIT as well, as the cell store has a
// registered read port. A clear walks the store one cell a cycle; a scroll copies each
// cell one row up through the single read and write port and then blanks the bottom
// row. After reset a clearing pass over all ROWS*COLUMNS cells (2000 at the default
// size) fills the store with blanks in attribute 7; in_ch.ready stays low throughout,
// while attribute writes on cfg_ch are taken at once in every cycle. A two-entry queue
// between front and back lets input be taken while a result waits.
module text_mode_console_writer_top import tmcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  tmcw_in_if.sink     in_ch,
  tmcw_out_if.source  out_ch,
  tmcw_cfg_if.sink    cfg_ch
);

  // classified command from the front register into the queue
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;

  // head of the queue towards the back end
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;

  // back-end status; hold input off during the clearing pass
  back_stat_t stat;

  tmcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .stat       (stat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tmcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tmcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_cmd   (pop_cmd),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .stat    (stat)
  );

endmodule

>>> tb/sv/tb_console_pkg.sv
// Screen predictor and result checker for the text-mode console writer bench.
// Keeps its own copy of the cell store, cursor and attribute; depends on tmcw_pkg.
package tb_console_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import tmcw_pkg::*;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  // opcode value the block leaves without effect
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [15:0] cell_val;
    logic        scrolled;
  } console_status_t;

  class console_scoreboard;
    logic [15:0]     cells [SCREEN_CELLS];
    int              cur_row;
    int              cur_col;
    logic [7:0]      attr;
    console_status_t status_due [$];
    int              mismatches;
    int              scrolls;
    int              clears;
    int              reads;

    function new();
      attr       = RESET_ATTR;
      cur_row    = 0;
      cur_col    = 0;
      mismatches = 0;
      scrolls    = 0;
      clears     = 0;
      reads      = 0;
      fill_blank();
    endfunction

    function logic [15:0] blank_cell();
      return {attr, CH_BLANK};
    endfunction

    function void fill_blank();
      foreach (cells[i]) cells[i] = blank_cell();
    endfunction

    function void set_attribute(logic [7:0] value);
      attr = value;
    endfunction

    // move every row up by one and blank the bottom row
    function void scroll_up();
      for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
      for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) cells[i] = blank_cell();
    endfunction

    function bit emit(logic [7:0] ch);
      bit rolled = 1'b0;
      case (ch)
        CH_LF: begin
          cur_col = 0;
          cur_row++;
        end
        CH_CR: cur_col = 0;
        CH_TAB: cur_col = (cur_col + 8) & ~7;
        CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            cells[cur_row * SCREEN_COLS + cur_col] = blank_cell();
          end
        end
        default: begin
          cells[cur_row * SCREEN_COLS + cur_col] = {attr, ch};
          cur_col++;
        end
      endcase
      if (cur_col >= SCREEN_COLS) begin
        cur_col = 0;
        cur_row++;
      end
      while (cur_row >= SCREEN_ROWS) begin
        scroll_up();
        cur_row--;
        rolled = 1'b1;
      end
      return rolled;
    endfunction

    // apply one accepted command and queue the status it must produce
    function void note_command(logic [1:0] op, logic [7:0] ch, logic [IDX_W-1:0] idx);
      console_status_t s;
      s.cell_val = '0;
      s.scrolled = 1'b0;
      case (op)
        OP_EMIT: s.scrolled = emit(ch);
        OP_CLEAR: begin
          fill_blank();
          cur_row = 0;
          cur_col = 0;
          clears++;
        end
        OP_READ: begin
          reads++;
          if (idx < SCREEN_CELLS) s.cell_val = cells[idx];
        end
        default: ;
      endcase
      if (s.scrolled) scrolls++;
      s.row = 5'(cur_row);
      s.col = 7'(cur_col);
      status_due.push_back(s);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [4:0] row, logic [6:0] col, logic [15:0] cell_val,
                               logic scrolled);
      console_status_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual row %0d col %0d cell 0x%0h",
                 $time, row, col, cell_val);
        return;
      end
      want = status_due.pop_front();
      compare_field("cursor_row", 16'(want.row), 16'(row));
      compare_field("cursor_col", 16'(want.col), 16'(col));
      compare_field("cell_value", want.cell_val, cell_val);
      compare_field("scrolled", 16'(want.scrolled), 16'(scrolled));
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
// Top-level bench for the text-mode console writer: drives commands and attribute
// writes, predicts every status with console_scoreboard and checks each result.
// Depends on tmcw_pkg, the tmcw interfaces, tb_console_pkg and the RTL top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmcw_pkg::*;
  import tb_console_pkg::*;

  // a clear or a scroll walks the whole store, and the clearing pass after reset
  // does the same; allow several of those plus the longest gaps on both sides
  localparam int WATCHDOG_LIMIT = 4 * (SCREEN_CELLS + 250);
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 1325;
  localparam int PHASES         = 5;
  localparam int MAX_IDLE       = 12;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tmcw_in_if  in_ch ();
  tmcw_out_if out_ch ();
  tmcw_cfg_if cfg_ch ();

  text_mode_console_writer_top #(
    .COLUMNS (SCREEN_COLS),
    .ROWS    (SCREEN_ROWS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  console_scoreboard screen;
  int items_sent     = 0;
  int attr_settings  = 1;
  bit tx_eager       = 1'b0;
  bit rx_eager       = 1'b0;

  // Result side: draw a stall per transaction, drop ready for that long, then hold
  // ready high until a result is taken. Flip into eager mode now and then so that
  // long stretches run with no stall at all.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, MAX_IDLE);
      if ($urandom_range(0, 49) == 0) rx_eager = !rx_eager;
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      screen.check_result(out_ch.cursor_row, out_ch.cursor_col, out_ch.cell_value,
                          out_ch.scrolled);
    end
  end

  // Watchdog: count cycles in which no channel moves a transaction.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one command: idle for a drawn gap, present it at the falling edge and
  // hold it until the block takes it, then note it in the predictor.
  task automatic send_command(logic [1:0] op, logic [7:0] ch, logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_IDLE);
    if ($urandom_range(0, 49) == 0) tx_eager = !tx_eager;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode     = op;
    in_ch.char_code  = ch;
    in_ch.cell_index = idx;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    screen.note_command(op, ch, idx);
    items_sent++;
  endtask

  // Drop valid and hold off until every predicted status has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (screen.status_due.size() != 0) @(posedge clk);
  endtask

  // Write the attribute register only once the block has gone quiet.
  task automatic write_attribute(logic [7:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.text_attribute = value;
    cfg_ch.valid          = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    screen.set_attribute(value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    attr_settings++;
  endtask

  // One line of text: mostly printable characters with backspaces, tabs and
  // reads mixed in, a little noise, and a line ending. Short lines dominate so
  // the cursor reaches the bottom row often and the screen scrolls; a few long
  // lines run past the right edge and wrap.
  task automatic send_line();
    int len;
    int pick;
    int ending;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(70, 170);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        send_command(OP_EMIT, 8'($urandom_range(8'h20, 8'h7E)), 11'($urandom_range(0, 2047)));
      end else if (pick < 70) begin
        send_command(OP_EMIT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else if (pick < 77) begin
        send_command(OP_EMIT, CH_BS, 11'($urandom_range(0, 2047)));
      end else if (pick < 82) begin
        send_command(OP_EMIT, CH_TAB, 11'($urandom_range(0, 2047)));
      end else if (pick < 84) begin
        send_command(OP_EMIT, CH_CR, 11'($urandom_range(0, 2047)));
      end else if (pick < 96) begin
        // read back around the cursor row, where the latest writes landed
        send_command(OP_READ, 8'($urandom_range(0, 255)),
                     11'(screen.cur_row * SCREEN_COLS +
                         int'($urandom_range(0, SCREEN_COLS - 1))));
      end else if (pick < 98) begin
        send_command(OP_READ, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else begin
        send_command(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end
      if ($urandom_range(0, 149) == 0) hold_until_drained();
    end
    ending = $urandom_range(0, 99);
    if (ending < 70) begin
      send_command(OP_EMIT, CH_LF, 11'($urandom_range(0, 2047)));
    end else if (ending < 85) begin
      send_command(OP_EMIT, CH_CR, 11'($urandom_range(0, 2047)));
      send_command(OP_EMIT, CH_LF, 11'($urandom_range(0, 2047)));
    end else if (ending < 95) begin
      send_command(OP_EMIT, CH_CR, 11'($urandom_range(0, 2047)));
    end
    if ($urandom_range(0, 39) == 0) send_command(OP_CLEAR, 8'($urandom_range(0, 255)), '0);
  endtask

  initial begin : stimulus
    int target;
    logic [7:0] phase_attr;
    screen                = new();
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.opcode          = OP_EMIT;
    in_ch.char_code       = '0;
    in_ch.cell_index      = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.text_attribute = RESET_ATTR;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, under the reset attribute: reads of the blank store at both
    // ends and past its end, the unused opcode, extreme character codes, every
    // control code including backspace at the left edge, a clear, and tabs that
    // run off the right edge and wrap.
    send_command(OP_READ, 8'h00, '0);
    send_command(OP_READ, 8'h00, 11'(SCREEN_CELLS - 1));
    send_command(OP_READ, 8'h00, 11'(SCREEN_CELLS));
    send_command(OP_READ, 8'hFF, '1);
    send_command(OP_UNUSED, 8'h41, 11'h3FF);
    send_command(OP_EMIT, 8'h48, '0);
    send_command(OP_EMIT, 8'h00, '0);
    send_command(OP_EMIT, 8'hFF, '1);
    send_command(OP_READ, 8'h00, 11'd1);
    send_command(OP_EMIT, CH_BS, '0);
    send_command(OP_READ, 8'h00, 11'd2);
    send_command(OP_EMIT, CH_TAB, '0);
    send_command(OP_EMIT, CH_CR, '0);
    send_command(OP_EMIT, CH_BS, '0);
    send_command(OP_EMIT, CH_LF, '0);
    send_command(OP_CLEAR, 8'h00, '0);
    send_command(OP_READ, 8'h00, '0);
    repeat (SCREEN_COLS / 8) send_command(OP_EMIT, CH_TAB, '0);

    // Random part: one attribute per phase, the extremes first, then random ones.
    // Every other phase opens with a clear so the blanks take the new attribute.
    for (int phase = 0; phase < PHASES; phase++) begin
      phase_attr = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      write_attribute(phase_attr);
      if (phase % 2 == 1) send_command(OP_CLEAR, 8'($urandom_range(0, 255)), '0);
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) send_line();
    end

    // Drain, then give the block time to show any stray result.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands under %0d attribute settings: %0d scrolls, %0d clears,",
             items_sent, attr_settings, screen.scrolls, screen.clears);
    $display("%0d cell reads; %0d mismatches found.", screen.reads, screen.mismatches);
    if (screen.mismatches == 0 && screen.status_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
